FILE: hw/rtl/circular_queue_with_search_core_defines.svh
// Assertion macros shared by the queue block. Each macro expects signals
// named clk and rst_n in the scope where it is used.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define CQS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CQS_ASSERT_SAME(lbl, ante, cons, msg)
`define CQS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/cqs_pkg.sv
package cqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int FIELD5_W  = 5;
    localparam int OUT_W     = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic push_wr;
        logic pop_rd;
        logic scan_start;
        logic scan_step;
        logic set_err;
        err_t err;
        logic set_found;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  hit;
        logic  last;
    } sts_t;

endpackage

FILE: hw/rtl/cqs_dp.sv
module cqs_dp
    import cqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SCAN_W = CNT_W + 1;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0]  cap_reg;
    logic [PTR_W-1:0]  head_reg, tail_reg, scan_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  cap_eff;
    mode_t             mode_reg;
    logic [DATA_W-1:0] key_reg;
    logic [SCAN_W-1:0] scan_pos_reg, cmp_pos_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              res_found_reg;
    logic [SCAN_W-1:0] res_pos_reg;
    err_t              res_err_reg;
    logic              res_pop_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic [PTR_W-1:0]  rd_addr;
    logic [31:0]       cnt_wide, pos_wide;
    logic [DATA_W-1:0] data_sel;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] idx,
                                             input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        logic [PTR_W-1:0] res;
        begin
            nxt = CNT_W'(idx) + CNT_W'(1);
            res = (nxt >= cap) ? '0 : PTR_W'(nxt);
            return res;
        end
    endfunction

    // A capacity of zero is raised to one; values above the ring size are clamped to the ring size.
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(cap_reg) > DEPTH)
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = CNT_W'(cap_reg);
    end

    assign sts.mode  = mode_reg;
    assign sts.full  = (count_reg >= cap_eff);
    assign sts.empty = (count_reg == '0);
    assign sts.hit   = rd_valid_reg && (rd_data_reg == key_reg);
    assign sts.last  = rd_valid_reg && (cmp_pos_reg == SCAN_W'(count_reg));

    assign rd_addr = cmd.pop_rd ? head_reg : scan_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
            mem[tail_reg] <= key_reg;
        if (cmd.pop_rd || cmd.scan_step)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step && (scan_pos_reg <= SCAN_W'(count_reg));
            if (cfg_wr_en)
            begin
                cap_reg   <= cfg_wr_data;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.push_wr)
            begin
                tail_reg  <= adv(tail_reg, cap_eff);
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pop_rd)
            begin
                head_reg  <= adv(head_reg, cap_eff);
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg      <= mode_t'(s_tuser);
            key_reg       <= s_tdata;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
            res_err_reg   <= ERR_OK;
            res_pop_reg   <= 1'b0;
        end
        if (cmd.set_err)
        begin
            res_err_reg <= cmd.err;
            res_pop_reg <= cmd.pop_rd;
        end
        if (cmd.scan_start)
        begin
            scan_ptr_reg <= head_reg;
            scan_pos_reg <= SCAN_W'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_reg <= adv(scan_ptr_reg, cap_eff);
            scan_pos_reg <= scan_pos_reg + SCAN_W'(1);
            cmp_pos_reg  <= scan_pos_reg;
        end
        if (cmd.set_found)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= cmp_pos_reg;
        end
        if (cmd.out_load)
            m_tdata_reg <= {1'b0, cnt_wide[FIELD5_W-1:0], sts.full, sts.empty,
                            res_err_reg, pos_wide[FIELD5_W-1:0], res_found_reg,
                            data_sel};
    end

    assign cnt_wide = 32'(count_reg);
    assign pos_wide = 32'(res_pos_reg);
    assign data_sel = res_pop_reg ? rd_data_reg : '0;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/cqs_ctrl.sv
module cqs_ctrl
    import cqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.err    = ERR_OK;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.set_err = 1'b1;
                state_next  = ST_RESULT;
                unique case (sts.mode)
                    MODE_PUSH:
                    begin
                        if (sts.full)
                            cmd.err = ERR_FULL;
                        else
                            cmd.push_wr = 1'b1;
                    end
                    MODE_POP:
                    begin
                        if (sts.empty)
                            cmd.err = ERR_EMPTY;
                        else
                            cmd.pop_rd = 1'b1;
                    end
                    MODE_SEARCH:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.err = ERR_OK;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.set_found = sts.hit;
                if (sts.hit || sts.last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd.out_load = !m_tvalid_reg || m_tready;
                if (cmd.out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

FILE: hw/rtl/circular_queue_with_search_core.sv
// Each request passes through the execute state, the scan state for a
// search of a non-empty queue, and the result state, which loads the output
// register once it is free. A new request is taken only after the last
// result has been loaded into the output register.
// Reset (rst_n, asynchronous, active low) empties the queue and sets the
// capacity register to 16; slot contents are not cleared.
`include "circular_queue_with_search_core_defines.svh"

module circular_queue_with_search_core
    import cqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Capacity register write port.
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    // Request channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]        s_tuser,   // [1:0] mode
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    // [31:0] data_out, [32] found, [37:33] position, [39:38] error,
    // [40] is_empty, [41] is_full, [46:42] count, [47] zero
    output logic [OUT_W-1:0]  m_tdata
);

    // The controller walks each request through execute, an optional scan
    // and a result stage. The datapath holds the ring memory, the head and
    // tail pointers, the count and the output register. Once a result is in
    // the output register the controller returns to idle and can take the
    // next request while the result is still waiting to be taken.
    cmd_t cmd;
    sts_t sts;

    cqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // A search reads one slot per cycle starting at the head and compares
    // the registered read data in the next cycle, so the scan is pipelined
    // by one stage and stops at the first match or after the last entry.
    cqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tdata     (m_tdata)
    );

    // Only one request is in flight: after a request is taken the block is
    // busy on the next cycle.
    `CQS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
                     "second request taken while busy")

    // A queue with at least one slot can never be both empty and full.
    `CQS_ASSERT_SAME(a_flags_exclusive, m_tvalid, !(m_tdata[40] && m_tdata[41]),
                     "empty and full together")

    // A found flag always comes with a nonzero position, and only then.
    `CQS_ASSERT_SAME(a_found_pos, m_tvalid, m_tdata[32] == (m_tdata[37:33] != 5'd0),
                     "found and position disagree")

    // A failed push or pop returns no data and no match.
    `CQS_ASSERT_SAME(a_err_no_data, m_tvalid && (m_tdata[39:38] != ERR_OK),
                     (m_tdata[31:0] == '0) && !m_tdata[32], "data on an error result")

endmodule
